### rtl/scc_pkg.sv
// Shared types and constants for the strongly connected components block.
// No dependencies; the other files of the block but scc_first_set refer to it by scoped names.
package scc_pkg;

    localparam int VERT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // write request into one adjacency matrix
    typedef struct packed {
        logic              we;
        logic              clr;
        logic [VERT_W-1:0] row;
        logic [VERT_W-1:0] col;
    } adj_wr_t;

    // depth-first stack entry: vertex and next neighbour to try
    typedef struct packed {
        logic [VERT_W-1:0]  v;
        logic [COUNT_W-1:0] nx;
    } stk_entry_t;

endpackage

### rtl/scc_ifs.sv
// Valid/ready channel interfaces for requests and results.
// Depends on scc_pkg for field widths.
interface scc_req_if;
    logic                          valid;
    logic                          ready;
    logic [scc_pkg::KIND_W-1:0]    kind;
    logic [scc_pkg::VERT_W-1:0]    from_vertex;
    logic [scc_pkg::VERT_W-1:0]    to_vertex;

    modport source (output valid, kind, from_vertex, to_vertex, input ready);
    modport sink   (input valid, kind, from_vertex, to_vertex, output ready);
endinterface

interface scc_res_if;
    logic                          valid;
    logic                          ready;
    logic [scc_pkg::VERT_W-1:0]    vertex;
    logic [scc_pkg::VERT_W-1:0]    component;
    logic                          last_in_component;
    logic                          last;

    modport source (output valid, vertex, component, last_in_component, last, input ready);
    modport sink   (input valid, vertex, component, last_in_component, last, output ready);
endinterface

### rtl/scc_first_set.sv
// Shared neighbour search unit: lowest set bit of a candidate row.
// Depends on nothing but its parameters.
module scc_first_set #(
    parameter int NV = 64,
    parameter int VW = 6
) (
    input  logic [NV-1:0] cand,
    output logic          found,
    output logic [VW-1:0] idx
);

    always_comb
    begin
        idx = '0;
        for (int b = NV - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                idx = VW'(b);
            end
        end
    end

    assign found = |cand;

endmodule

### rtl/scc_adj_mem.sv
// One adjacency bit matrix with per-row valid bits for fast clear.
// Depends on scc_pkg (adj_wr_t).
module scc_adj_mem #(
    parameter int NV = 64,
    parameter int VW = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  scc_pkg::adj_wr_t wr,
    input  logic [VW-1:0]    rd_row,
    output logic [NV-1:0]    rd_data
);

    logic [NV-1:0] rows [NV];
    logic [NV-1:0] row_valid_reg;
    logic [NV-1:0] rd_q_reg;
    logic          rd_vld_reg;
    logic [VW-1:0] wr_row;
    logic [VW-1:0] wr_col;

    assign wr_row = wr.row[VW-1:0];
    assign wr_col = wr.col[VW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr.clr)
        begin
            row_valid_reg <= '0;
        end
        else if (wr.we)
        begin
            row_valid_reg[wr_row] <= 1'b1;
        end
    end

    // an invalid row is rewritten whole so stale bits vanish
    always_ff @(posedge clk)
    begin
        if (wr.we && !wr.clr)
        begin
            if (!row_valid_reg[wr_row])
            begin
                rows[wr_row] <= NV'(1) << wr_col;
            end
            else
            begin
                rows[wr_row][wr_col] <= 1'b1;
            end
        end
        rd_q_reg   <= rows[rd_row];
        rd_vld_reg <= row_valid_reg[rd_row];
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

### rtl/strongly_connected_components.sv
// Kosaraju SCC engine. Edge add and clear requests are accepted only while idle and leave it idle.
// A run keeps the block busy until both passes finish: each vertex costs a row read and
// a lowest-set-bit step on entry and again on return to its parent in both passes, plus
// the scans over start vertices, and output stalls in the second pass add to this.
// A result leaves one register late, when the next one is found or the run ends.
// Reset: both matrices empty (row valid bits cleared at once), vertex_count = 64.
module strongly_connected_components #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [scc_pkg::COUNT_W-1:0]   cfg_write_data,
    scc_req_if.sink                       cmd,
    scc_res_if.source                     result
);

    localparam int NV  = MAX_VERTICES;
    localparam int VW  = $clog2(NV);
    localparam int CW  = scc_pkg::COUNT_W;
    localparam int VTW = scc_pkg::VERT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_P1_SCAN,
        S_P2_SCAN,
        S_P2_FO,
        S_READ,
        S_STEP,
        S_POP,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic                 pass2_reg;
    logic [CW-1:0]        vcount_reg;
    logic [NV-1:0]        visited_reg;
    logic [CW-1:0]        scan_reg;
    logic [CW-1:0]        ft_reg;
    logic [CW-1:0]        sp_reg;
    logic [VTW-1:0]       cur_v_reg;
    logic [CW-1:0]        cur_nx_reg;
    logic [VTW-1:0]       comp_reg;
    logic                 pend_valid_reg;
    logic [VTW-1:0]       pend_v_reg;
    logic [VTW-1:0]       pend_c_reg;
    logic                 pend_lic_reg;
    logic                 out_valid_reg;
    logic [VTW-1:0]       out_v_reg;
    logic [VTW-1:0]       out_c_reg;
    logic                 out_lic_reg;
    logic                 out_last_reg;

    scc_pkg::stk_entry_t  stk [NV];
    scc_pkg::stk_entry_t  stk_q_reg;
    logic [VTW-1:0]       fo [NV];
    logic [VTW-1:0]       fo_q_reg;

    logic [CW-1:0]        n_eff;
    logic [NV-1:0]        nmask;
    logic [NV-1:0]        fmask;
    logic [NV-1:0]        fwd_row;
    logic [NV-1:0]        rev_row;
    logic [NV-1:0]        cand;
    logic                 found;
    logic [VW-1:0]        w_idx;
    logic [VTW-1:0]       w;
    logic                 oslot_free;
    logic                 ostall;
    logic                 accept;
    logic                 edge_ok;
    scc_pkg::adj_wr_t     fwd_wr;
    scc_pkg::adj_wr_t     rev_wr;
    logic [VW-1:0]        stk_raddr;
    logic [VW-1:0]        fo_raddr;
    logic [VW-1:0]        start_idx;

    assign n_eff = (vcount_reg > CW'(NV)) ? CW'(NV) : vcount_reg;

    always_comb
    begin
        for (int b = 0; b < NV; b++)
        begin
            nmask[b] = CW'(b) < n_eff;
            fmask[b] = CW'(b) >= cur_nx_reg;
        end
    end

    assign accept  = cmd.valid && cmd.ready;
    assign edge_ok = (CW'(cmd.from_vertex) < n_eff) && (CW'(cmd.to_vertex) < n_eff);

    always_comb
    begin
        fwd_wr.we  = accept && (cmd.kind == scc_pkg::KIND_ADD) && edge_ok;
        fwd_wr.clr = accept && (cmd.kind == scc_pkg::KIND_CLEAR);
        fwd_wr.row = cmd.from_vertex;
        fwd_wr.col = cmd.to_vertex;
        rev_wr     = fwd_wr;
        rev_wr.row = cmd.to_vertex;
        rev_wr.col = cmd.from_vertex;
    end

    scc_adj_mem #(.NV(NV), .VW(VW)) u_fwd (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (fwd_wr),
        .rd_row  (cur_v_reg[VW-1:0]),
        .rd_data (fwd_row)
    );

    scc_adj_mem #(.NV(NV), .VW(VW)) u_rev (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (rev_wr),
        .rd_row  (cur_v_reg[VW-1:0]),
        .rd_data (rev_row)
    );

    assign cand = (pass2_reg ? rev_row : fwd_row) & ~visited_reg & nmask & fmask;

    scc_first_set #(.NV(NV), .VW(VW)) u_ffs (
        .cand  (cand),
        .found (found),
        .idx   (w_idx)
    );

    assign w          = VTW'(w_idx);
    assign oslot_free = !out_valid_reg || result.ready;
    assign ostall     = pend_valid_reg && !oslot_free;
    assign stk_raddr  = VW'(sp_reg - CW'(2));
    assign fo_raddr   = VW'(scan_reg - CW'(1));
    assign start_idx  = fo_q_reg[VW-1:0];

    always_ff @(posedge clk)
    begin
        stk_q_reg <= stk[stk_raddr];
        fo_q_reg  <= fo[fo_raddr];
        if (state_reg == S_STEP && found && !(pass2_reg && ostall))
        begin
            stk[VW'(sp_reg - CW'(1))] <= '{v: cur_v_reg, nx: CW'(w) + CW'(1)};
        end
        if (state_reg == S_STEP && !found && !pass2_reg)
        begin
            fo[ft_reg[VW-1:0]] <= cur_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= CW'(64);
        end
        else if (cfg_write_en)
        begin
            vcount_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pass2_reg      <= 1'b0;
            visited_reg    <= '0;
            scan_reg       <= '0;
            ft_reg         <= '0;
            sp_reg         <= '0;
            comp_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_v_reg      <= '0;
            cur_nx_reg     <= '0;
        end
        else
        begin
            if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && cmd.kind == scc_pkg::KIND_RUN && n_eff != '0)
                    begin
                        visited_reg <= '0;
                        ft_reg      <= '0;
                        comp_reg    <= '0;
                        scan_reg    <= '0;
                        pass2_reg   <= 1'b0;
                        state_reg   <= S_P1_SCAN;
                    end
                end
                S_P1_SCAN:
                begin
                    if (scan_reg == n_eff)
                    begin
                        visited_reg <= '0;
                        scan_reg    <= n_eff;
                        pass2_reg   <= 1'b1;
                        state_reg   <= S_P2_SCAN;
                    end
                    else if (visited_reg[scan_reg[VW-1:0]])
                    begin
                        scan_reg <= scan_reg + CW'(1);
                    end
                    else
                    begin
                        visited_reg[scan_reg[VW-1:0]] <= 1'b1;
                        cur_v_reg  <= VTW'(scan_reg);
                        cur_nx_reg <= '0;
                        sp_reg     <= CW'(1);
                        state_reg  <= S_READ;
                    end
                end
                S_P2_SCAN:
                begin
                    state_reg <= (scan_reg == '0) ? S_DONE : S_P2_FO;
                end
                S_P2_FO:
                begin
                    if (visited_reg[start_idx])
                    begin
                        scan_reg  <= scan_reg - CW'(1);
                        state_reg <= S_P2_SCAN;
                    end
                    else if (!ostall)
                    begin
                        scan_reg               <= scan_reg - CW'(1);
                        visited_reg[start_idx] <= 1'b1;
                        cur_v_reg              <= fo_q_reg;
                        cur_nx_reg             <= '0;
                        sp_reg                 <= CW'(1);
                        if (pend_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                        end
                        pend_valid_reg <= 1'b1;
                        state_reg      <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    if (found)
                    begin
                        if (!(pass2_reg && ostall))
                        begin
                            visited_reg[w_idx] <= 1'b1;
                            cur_v_reg          <= w;
                            cur_nx_reg         <= '0;
                            sp_reg             <= sp_reg + CW'(1);
                            state_reg          <= S_READ;
                            if (pass2_reg)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_reg <= 1'b1;
                                end
                                pend_valid_reg <= 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        sp_reg <= sp_reg - CW'(1);
                        if (!pass2_reg)
                        begin
                            ft_reg <= ft_reg + CW'(1);
                        end
                        priority if (sp_reg == CW'(1))
                        begin
                            if (pass2_reg)
                            begin
                                comp_reg  <= comp_reg + VTW'(1);
                                state_reg <= S_P2_SCAN;
                            end
                            else
                            begin
                                state_reg <= S_P1_SCAN;
                            end
                        end
                        else
                        begin
                            state_reg <= S_POP;
                        end
                    end
                end
                S_POP:
                begin
                    cur_v_reg  <= stk_q_reg.v;
                    cur_nx_reg <= stk_q_reg.nx;
                    state_reg  <= S_READ;
                end
                S_DONE:
                begin
                    if (oslot_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result payload: pending entry moves out when the next one arrives or the run ends
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_P2_FO && !visited_reg[start_idx] && !ostall)
            || (state_reg == S_STEP && pass2_reg && found && !ostall))
        begin
            // first result of a run leaves the output register alone
            if (pend_valid_reg)
            begin
                out_v_reg    <= pend_v_reg;
                out_c_reg    <= pend_c_reg;
                out_lic_reg  <= pend_lic_reg;
                out_last_reg <= 1'b0;
            end
            pend_v_reg   <= (state_reg == S_P2_FO) ? fo_q_reg : w;
            pend_c_reg   <= comp_reg;
            pend_lic_reg <= 1'b0;
        end
        else if (state_reg == S_STEP && pass2_reg && !found && sp_reg == CW'(1))
        begin
            pend_lic_reg <= 1'b1;
        end
        else if (state_reg == S_DONE && oslot_free)
        begin
            out_v_reg    <= pend_v_reg;
            out_c_reg    <= pend_c_reg;
            out_lic_reg  <= pend_lic_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign cmd.ready                = (state_reg == S_IDLE);
    assign result.valid             = out_valid_reg;
    assign result.vertex            = out_v_reg;
    assign result.component         = out_c_reg;
    assign result.last_in_component = out_lic_reg;
    assign result.last              = out_last_reg;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= CW'(NV))
        else $error("stack depth exceeds vertex limit");

    a_finish_all: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P2_SCAN) |-> (ft_reg == n_eff))
        else $error("first pass did not finish every vertex");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.last) |-> result.last_in_component)
        else $error("final result does not close a component");

    a_pend_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> pend_valid_reg)
        else $error("run ended with no pending result");
`endif

endmodule

### dv/tb.sv
// Self-checking bench for the strongly connected components engine.
// Depends on rtl/scc_pkg.sv, rtl/scc_ifs.sv and the top module strongly_connected_components.
module tb;

    typedef struct packed {
        logic [scc_pkg::KIND_W-1:0] kind;
        logic [scc_pkg::VERT_W-1:0] from_vertex;
        logic [scc_pkg::VERT_W-1:0] to_vertex;
    } request_t;

    typedef struct packed {
        logic [scc_pkg::VERT_W-1:0] vertex;
        logic [scc_pkg::VERT_W-1:0] component;
        logic                       last_in_component;
        logic                       last;
    } scc_result_t;

    localparam logic [scc_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [scc_pkg::COUNT_W-1:0] cfg_write_data;

    scc_req_if cmd_bus ();
    scc_res_if res_bus ();

    strongly_connected_components i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd_bus.sink),
        .result         (res_bus.source)
    );

    // predictor state
    logic [63:0] fwd_adj [64];
    logic [63:0] rev_adj [64];
    logic [scc_pkg::COUNT_W-1:0] vcount_shadow;

    request_t    pending_requests [$];
    scc_result_t expected_results [$];

    int mismatches;
    int results_seen;
    int runs_sent;
    logic idle_enable;
    logic sender_hold;
    int   recv_hold_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int lowest_open(input logic [63:0] cand);
        for (int b = 0; b < 64; b++)
        begin
            if (cand[b])
                return b;
        end
        return 64;
    endfunction

    // Kosaraju: forward DFS for finish order, then transposed DFS
    task automatic predict_components();
        int n;
        logic [63:0] nmask;
        logic [63:0] seen;
        int fin [64];
        int fin_cnt;
        int stk_v [64];
        int stk_nx [64];
        int sp;
        int v;
        int w;
        int comp;
        int start;
        scc_result_t r;
        n = (vcount_shadow > 64) ? 64 : int'(vcount_shadow);
        if (n == 0)
            return;
        nmask = (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
        seen = '0;
        fin_cnt = 0;
        for (int s = 0; s < n; s++)
        begin
            if (seen[s])
                continue;
            seen[s] = 1'b1;
            sp = 1;
            stk_v[0] = s;
            stk_nx[0] = 0;
            while (sp > 0)
            begin
                v = stk_v[sp-1];
                w = (stk_nx[sp-1] >= 64) ? 64 :
                    lowest_open(fwd_adj[v] & ~seen & nmask & ({64{1'b1}} << stk_nx[sp-1]));
                if (w < 64)
                begin
                    stk_nx[sp-1] = w + 1;
                    seen[w] = 1'b1;
                    stk_v[sp] = w;
                    stk_nx[sp] = 0;
                    sp++;
                end
                else
                begin
                    sp--;
                    fin[fin_cnt] = v;
                    fin_cnt++;
                end
            end
        end
        seen = '0;
        comp = 0;
        for (int i = n - 1; i >= 0; i--)
        begin
            start = fin[i];
            if (seen[start])
                continue;
            seen[start] = 1'b1;
            sp = 1;
            stk_v[0] = start;
            stk_nx[0] = 0;
            r = '{vertex: start[5:0], component: comp[5:0], last_in_component: 1'b0,
                  last: 1'b0};
            expected_results.push_back(r);
            while (sp > 0)
            begin
                v = stk_v[sp-1];
                w = (stk_nx[sp-1] >= 64) ? 64 :
                    lowest_open(rev_adj[v] & ~seen & nmask & ({64{1'b1}} << stk_nx[sp-1]));
                if (w < 64)
                begin
                    stk_nx[sp-1] = w + 1;
                    seen[w] = 1'b1;
                    stk_v[sp] = w;
                    stk_nx[sp] = 0;
                    sp++;
                    r = '{vertex: w[5:0], component: comp[5:0], last_in_component: 1'b0,
                          last: 1'b0};
                    expected_results.push_back(r);
                end
                else
                begin
                    sp--;
                end
            end
            expected_results[$].last_in_component = 1'b1;
            comp = (comp + 1) % 64;
        end
        expected_results[$].last = 1'b1;
    endtask

    task automatic predict_request(input request_t req);
        int n;
        n = (vcount_shadow > 64) ? 64 : int'(vcount_shadow);
        case (req.kind)
            scc_pkg::KIND_ADD:
            begin
                if (req.from_vertex < n && req.to_vertex < n)
                begin
                    fwd_adj[req.from_vertex][req.to_vertex] = 1'b1;
                    rev_adj[req.to_vertex][req.from_vertex] = 1'b1;
                end
            end
            scc_pkg::KIND_CLEAR:
            begin
                for (int i = 0; i < 64; i++)
                begin
                    fwd_adj[i] = '0;
                    rev_adj[i] = '0;
                end
            end
            scc_pkg::KIND_RUN:
            begin
                runs_sent++;
                predict_components();
            end
            default:
            begin
            end
        endcase
    endtask

    // driver
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid       <= 1'b0;
            cmd_bus.kind        <= scc_pkg::KIND_ADD;
            cmd_bus.from_vertex <= '0;
            cmd_bus.to_vertex   <= '0;
            send_gap = 0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
                predict_request(request_t'({cmd_bus.kind, cmd_bus.from_vertex,
                                            cmd_bus.to_vertex}));
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (idle_enable && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 8);
                if (send_gap == 0 && !sender_hold && pending_requests.size() > 0)
                begin
                    request_t nxt;
                    nxt = pending_requests.pop_front();
                    cmd_bus.valid       <= 1'b1;
                    cmd_bus.kind        <= nxt.kind;
                    cmd_bus.from_vertex <= nxt.from_vertex;
                    cmd_bus.to_vertex   <= nxt.to_vertex;
                end
                else
                begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    int recv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                scc_result_t got;
                scc_result_t exp;
                got = '{vertex: res_bus.vertex, component: res_bus.component,
                        last_in_component: res_bus.last_in_component, last: res_bus.last};
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: vertex %0d component %0d",
                                 got.vertex, got.component);
                end
                else
                begin
                    exp = expected_results.pop_front();
                    if (got !== exp)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp v%0d c%0d lic%0b l%0b, ",
                                      "got v%0d c%0d lic%0b l%0b"},
                                     exp.vertex, exp.component, exp.last_in_component,
                                     exp.last, got.vertex, got.component,
                                     got.last_in_component, got.last);
                    end
                end
            end
            if (recv_hold_cycles > 0)
            begin
                recv_hold_cycles--;
                res_bus.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                res_bus.ready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(0, 7);
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    function automatic request_t mk(input logic [scc_pkg::KIND_W-1:0] k, input int f,
                                    input int t);
        request_t r;
        r.kind = k;
        r.from_vertex = f[5:0];
        r.to_vertex = t[5:0];
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_requests.size() > 0 || cmd_bus.valid || expected_results.size() > 0)
            @(posedge clk);
        // a run still searching after its last result, or a queued add
        repeat (2 * 64 * 64 + 4 * 64 + 50) @(posedge clk);
    endtask

    task automatic write_count(input int value);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value[scc_pkg::COUNT_W-1:0];
        vcount_shadow = value[scc_pkg::COUNT_W-1:0];
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // random graph of n vertices: a clear, chain edges a to a+1, random edges, stray adds and unused kinds, a run
    task automatic queue_graph(input int n, input int edges);
        int a;
        pending_requests.push_back(mk(scc_pkg::KIND_CLEAR, 0, 0));
        for (int e = 0; e < edges; e++)
        begin
            a = $urandom_range(0, n - 1);
            case ($urandom_range(0, 9))
                0: pending_requests.push_back(mk(scc_pkg::KIND_ADD, $urandom_range(0, 63),
                                                 $urandom_range(0, 63)));
                1: pending_requests.push_back(mk(KIND_UNUSED, $urandom_range(0, 63),
                                                 $urandom_range(0, 63)));
                2, 3, 4: pending_requests.push_back(mk(scc_pkg::KIND_ADD, a, (a + 1) % n));
                default: pending_requests.push_back(mk(scc_pkg::KIND_ADD, a,
                                                       $urandom_range(0, n - 1)));
            endcase
        end
        pending_requests.push_back(mk(scc_pkg::KIND_RUN, 0, 0));
    endtask

    initial begin
        int sizes [6];
        int n;
        clk = 1'b0;
        for (int i = 0; i < 64; i++)
        begin
            fwd_adj[i] = '0;
            rev_adj[i] = '0;
        end
        vcount_shadow    = 7'd64;
        mismatches       = 0;
        results_seen     = 0;
        runs_sent        = 0;
        idle_enable      = 1'b1;
        sender_hold      = 1'b1;
        recv_hold_cycles = 0;
        cfg_write_en     = 1'b0;
        cfg_write_data   = '0;
        rst_n            = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: edges at reset count, extremes, repeats, stale, unused kind
        pending_requests.push_back(mk(scc_pkg::KIND_ADD, 0, 63));
        pending_requests.push_back(mk(scc_pkg::KIND_ADD, 63, 0));
        pending_requests.push_back(mk(scc_pkg::KIND_ADD, 63, 0));
        pending_requests.push_back(mk(scc_pkg::KIND_ADD, 5, 5));
        pending_requests.push_back(mk(scc_pkg::KIND_ADD, 42, 21));
        pending_requests.push_back(mk(KIND_UNUSED, 63, 63));
        pending_requests.push_back(mk(scc_pkg::KIND_RUN, 63, 63));
        sender_hold = 1'b0;
        wait_drained();

        write_count(3);
        pending_requests.push_back(mk(scc_pkg::KIND_ADD, 0, 1));
        pending_requests.push_back(mk(scc_pkg::KIND_ADD, 1, 2));
        pending_requests.push_back(mk(scc_pkg::KIND_ADD, 2, 0));
        pending_requests.push_back(mk(scc_pkg::KIND_ADD, 2, 3));
        pending_requests.push_back(mk(scc_pkg::KIND_RUN, 0, 0));
        pending_requests.push_back(mk(scc_pkg::KIND_CLEAR, 0, 0));
        pending_requests.push_back(mk(scc_pkg::KIND_RUN, 0, 0));
        wait_drained();

        write_count(0);
        pending_requests.push_back(mk(scc_pkg::KIND_RUN, 0, 0));
        wait_drained();
        write_count(127);
        pending_requests.push_back(mk(scc_pkg::KIND_ADD, 10, 20));
        pending_requests.push_back(mk(scc_pkg::KIND_ADD, 20, 10));
        pending_requests.push_back(mk(scc_pkg::KIND_RUN, 0, 0));
        wait_drained();
        write_count(1);
        pending_requests.push_back(mk(scc_pkg::KIND_RUN, 0, 0));
        wait_drained();

        // long receiver stall while requests keep coming
        write_count(8);
        recv_hold_cycles = 300;
        for (int k = 0; k < 3; k++)
            queue_graph(8, 10);
        wait_drained();

        sizes = '{2, 5, 8, 12, 20, 64};
        for (int ph = 0; ph < 8; ph++)
        begin
            n = (ph == 7) ? 64 : sizes[$urandom_range(0, 4)];
            if (ph >= 6)
                idle_enable = 1'b0;
            write_count(n);
            for (int g = 0; g < 2; g++)
                queue_graph(n, $urandom_range(n, 2 * n > 24 ? 24 : 2 * n));
            wait_drained();
        end

        $display("%0d runs checked, %0d component results compared across sizes 0..127",
                 runs_sent, results_seen);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #60000000;
        $display("simulation failed");
        $finish;
    end
endmodule
